>>> design/fsdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdu_pkg: shared types and constants of the divide unit
// Opcodes, widths and the record that travels from front to back.
// ----------------------------------------------------------------------------
package fsdu_pkg;

    localparam int CELL_BITS = 32;
    localparam int DBL_BITS  = 2 * CELL_BITS;
    localparam int STEPS     = DBL_BITS;

    localparam logic [2:0] OP_SMOD   = 3'd0;
    localparam logic [2:0] OP_DMOD   = 3'd1;
    localparam logic [2:0] OP_FMMOD  = 3'd2;
    localparam logic [2:0] OP_SMREM  = 3'd3;
    localparam logic [2:0] OP_UMMOD  = 3'd4;
    localparam logic [2:0] OP_MULDIV = 3'd5;

    // Classified operation: magnitudes plus sign handling
    typedef struct packed {
        logic [DBL_BITS-1:0] mag_a;
        logic [DBL_BITS-1:0] mag_b;
        logic                neg_q;
        logic                neg_r;
        logic                neg_b;
        logic                floored;
        logic                dbl;
        logic                zero;
    } fsdu_op_t;

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic        divide_by_zero;
    } fsdu_res_t;

endpackage

>>> design/floored_symmetric_divide_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floored_symmetric_divide_unit: pipelined signed/unsigned divide unit
//
//   channel | dir | tdata fields (low bit up)                  | tuser
//   s_axis  | in  | dividend[63:0] multiplier[95:64]           | opcode[2:0]
//           |     | divisor[159:96]                            |
//   m_axis  | out | quotient[63:0] remainder[127:64] zero[128] | -
//
// One item accepted per cycle when not stalled; path: 2 decode stages, the
// queue, 1 entry stage, 64 divide stages (one quotient bit each), 1 fix-up
// stage. Reset clears only valid flags, queue pointers and count. Either
// side may stall; the queue decouples decode front and divide pipeline.
// ----------------------------------------------------------------------------
module floored_symmetric_divide_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // dividend, multiplier, divisor
    input  logic [2:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata   // quotient, remainder, divide_by_zero
);

    logic               f_valid, f_ready, q_valid, q_ready;
    fsdu_pkg::fsdu_op_t f_op, q_op;
    fsdu_pkg::fsdu_res_t res;

    // Decode front
    fsdu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .opcode     (s_axis_tuser),
        .dividend   (s_axis_tdata[63:0]),
        .multiplier (s_axis_tdata[95:64]),
        .divisor    (s_axis_tdata[159:96]),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_op     (f_op)
    );

    // Decoupling queue
    fsdu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    // Divide back end
    fsdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_op     (q_op),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {7'd0, res.divide_by_zero, res.remainder, res.quotient};

endmodule

>>> design/fsdu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdu_front: operand decode
// Two stages: operand selection and factor magnitudes, then product, magnitudes and signs.
// ----------------------------------------------------------------------------
module fsdu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           opcode,
    input  logic [63:0]          dividend,
    input  logic [31:0]          multiplier,
    input  logic [63:0]          divisor,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fsdu_pkg::fsdu_op_t   out_op
);

    localparam int CB = fsdu_pkg::CELL_BITS;
    localparam int DB = fsdu_pkg::DBL_BITS;

    logic           s1_valid_reg;
    logic [DB-1:0]  s1_a_reg, s1_b_reg;
    logic [CB-1:0]  s1_mx_reg, s1_my_reg;
    logic           s1_neg_p_reg, s1_mul_reg, s1_unsigned_reg;
    logic           s1_floored_reg, s1_dbl_reg, s1_bad_reg;
    logic           s2_valid_reg;
    fsdu_pkg::fsdu_op_t s2_op_reg, s2_op_next;
    logic           s1_adv, s2_adv;

    logic [CB-1:0]  x_c, y_c;
    logic [DB-1:0]  a_sel, b_sel;
    logic           is_mul, is_uns, is_dbl, is_bad;

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    // Operand selection per opcode
    always_comb
    begin
        x_c    = dividend[CB-1:0];
        y_c    = multiplier[CB-1:0];
        a_sel  = '0;
        b_sel  = {{(DB-CB){divisor[CB-1]}}, divisor[CB-1:0]};
        is_mul = 1'b0;
        is_uns = 1'b0;
        is_dbl = 1'b0;
        is_bad = 1'b0;
        unique case (opcode)
            fsdu_pkg::OP_SMOD:
            begin
                a_sel = {{(DB-CB){dividend[CB-1]}}, dividend[CB-1:0]};
            end
            fsdu_pkg::OP_DMOD:
            begin
                a_sel  = dividend[DB-1:0];
                b_sel  = divisor[DB-1:0];
                is_dbl = 1'b1;
            end
            fsdu_pkg::OP_FMMOD, fsdu_pkg::OP_SMREM:
            begin
                a_sel = dividend[DB-1:0];
            end
            fsdu_pkg::OP_UMMOD:
            begin
                a_sel  = dividend[DB-1:0];
                b_sel  = {{(DB-CB){1'b0}}, divisor[CB-1:0]};
                is_uns = 1'b1;
            end
            fsdu_pkg::OP_MULDIV:
            begin
                is_mul = 1'b1;
            end
            default:
            begin
                is_bad = 1'b1;
                b_sel  = '0;
            end
        endcase
    end

    // Stage 1: selected operands and factor magnitudes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_a_reg        <= a_sel;
            s1_b_reg        <= b_sel;
            s1_mx_reg       <= x_c[CB-1] ? (~x_c + 1'b1) : x_c;
            s1_my_reg       <= y_c[CB-1] ? (~y_c + 1'b1) : y_c;
            s1_neg_p_reg    <= x_c[CB-1] ^ y_c[CB-1];
            s1_mul_reg      <= is_mul;
            s1_unsigned_reg <= is_uns;
            s1_floored_reg  <= (opcode != fsdu_pkg::OP_SMREM);
            s1_dbl_reg      <= is_dbl;
            s1_bad_reg      <= is_bad;
        end
    end

    // Stage 2: product magnitude, operand magnitudes and result signs
    logic [DB-1:0] prod_c, a2_c;
    logic          sa_c, sb_c;
    always_comb
    begin
        prod_c = s1_mx_reg * s1_my_reg;
        if (s1_mul_reg)
        begin
            a2_c = prod_c;
            sa_c = s1_neg_p_reg && (prod_c != '0);
        end
        else
        begin
            sa_c = s1_a_reg[DB-1] && !s1_unsigned_reg;
            a2_c = sa_c ? (~s1_a_reg + 1'b1) : s1_a_reg;
        end
        sb_c = s1_b_reg[DB-1] && !s1_unsigned_reg;
        s2_op_next.mag_a   = a2_c;
        s2_op_next.mag_b   = sb_c ? (~s1_b_reg + 1'b1) : s1_b_reg;
        s2_op_next.neg_q   = sa_c ^ sb_c;
        s2_op_next.neg_r   = sa_c;
        s2_op_next.neg_b   = sb_c;
        s2_op_next.floored = s1_floored_reg && !s1_unsigned_reg;
        s2_op_next.dbl     = s1_dbl_reg;
        s2_op_next.zero    = (s1_b_reg == '0) && !s1_bad_reg;
        if (s1_bad_reg)
        begin
            s2_op_next.mag_a = '0;
            s2_op_next.neg_q = 1'b0;
            s2_op_next.neg_r = 1'b0;
            s2_op_next.neg_b = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_op_reg <= s2_op_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_op    = s2_op_reg;

endmodule

>>> design/fsdu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdu_queue: two-entry queue between front and back
// Lets the decode side and the divide pipeline stall independently.
// ----------------------------------------------------------------------------
module fsdu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsdu_pkg::fsdu_op_t in_op,
    output logic               out_valid,
    input  logic               out_ready,
    output fsdu_pkg::fsdu_op_t out_op
);

    fsdu_pkg::fsdu_op_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_op    = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_op;
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

>>> design/fsdu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdu_back: pipelined restoring divider and sign fix-up
// One quotient bit per stage over DBL_BITS stages, then the floored
// correction, then wrap and sign-extend; the last stage is the output.
// ----------------------------------------------------------------------------
module fsdu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fsdu_pkg::fsdu_op_t   in_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fsdu_pkg::fsdu_res_t  out_res
);

    localparam int DB = fsdu_pkg::DBL_BITS;
    localparam int CB = fsdu_pkg::CELL_BITS;
    localparam int NS = fsdu_pkg::STEPS;

    typedef struct packed {
        logic [DB-1:0] num;   // shifts out dividend bits, shifts in quotient
        logic [DB:0]   rem;
        logic [DB-1:0] mag_b;
        logic          neg_q;
        logic          neg_r;
        logic          neg_b;
        logic          floored;
        logic          dbl;
        logic          zero;
    } stage_t;

    stage_t          st_reg    [NS+1];
    logic [NS:0]     vld_reg;
    logic [NS+1:0]   adv;
    logic            fix_valid_reg;
    fsdu_pkg::fsdu_res_t fix_reg, fix_next;

    // Stall chain: a stage moves when the next one moves or is empty
    assign adv[NS+1] = !fix_valid_reg || out_ready;
    genvar g;
    generate
        for (g = 0; g <= NS; g++)
        begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate
    assign in_ready = adv[0];

    // Entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv[0])
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            st_reg[0].num     <= in_op.mag_a;
            st_reg[0].rem     <= '0;
            st_reg[0].mag_b   <= in_op.mag_b;
            st_reg[0].neg_q   <= in_op.neg_q;
            st_reg[0].neg_r   <= in_op.neg_r;
            st_reg[0].neg_b   <= in_op.neg_b;
            st_reg[0].floored <= in_op.floored;
            st_reg[0].dbl     <= in_op.dbl;
            st_reg[0].zero    <= in_op.zero;
        end
    end

    // One restoring step per stage
    generate
        for (g = 0; g < NS; g++)
        begin : g_step
            logic [DB:0] trial;
            logic [DB:0] diff;
            stage_t      nxt;
            always_comb
            begin
                trial = {st_reg[g].rem[DB-1:0], st_reg[g].num[DB-1]};
                diff  = trial - {1'b0, st_reg[g].mag_b};
                nxt   = st_reg[g];
                if (!diff[DB])
                begin
                    nxt.rem = diff;
                    nxt.num = {st_reg[g].num[DB-2:0], 1'b1};
                end
                else
                begin
                    nxt.rem = trial;
                    nxt.num = {st_reg[g].num[DB-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (adv[g+1])
                    vld_reg[g+1] <= vld_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (adv[g+1] && vld_reg[g])
                    st_reg[g+1] <= nxt;
            end
        end
    endgenerate

    // Floored correction, signs, wrap and sign-extend
    logic [DB-1:0] mq, mr, q_s, r_s;
    logic          bump;
    always_comb
    begin
        mq   = st_reg[NS].num;
        mr   = st_reg[NS].rem[DB-1:0];
        bump = st_reg[NS].floored && (mr != '0) && st_reg[NS].neg_q;
        if (bump)
        begin
            mq = mq + 1'b1;
            mr = st_reg[NS].mag_b - mr;
        end
        q_s = st_reg[NS].neg_q ? (~mq + 1'b1) : mq;
        r_s = (bump ? st_reg[NS].neg_b : st_reg[NS].neg_r) ? (~mr + 1'b1) : mr;
        fix_next.divide_by_zero = st_reg[NS].zero;
        if (st_reg[NS].zero || st_reg[NS].mag_b == '0)
        begin
            fix_next.quotient  = '0;
            fix_next.remainder = '0;
        end
        else if (st_reg[NS].dbl)
        begin
            fix_next.quotient  = 64'(signed'(q_s));
            fix_next.remainder = 64'(signed'(r_s));
        end
        else
        begin
            fix_next.quotient  = 64'(signed'(q_s[CB-1:0]));
            fix_next.remainder = 64'(signed'(r_s[CB-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fix_valid_reg <= 1'b0;
        else if (adv[NS+1])
            fix_valid_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS+1] && vld_reg[NS])
            fix_reg <= fix_next;
    end

    assign out_valid = fix_valid_reg;
    assign out_res   = fix_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_res))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.divide_by_zero) |->
        (out_res.quotient == '0 && out_res.remainder == '0))
        else $error("zero divisor with nonzero result");
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] |-> (st_reg[NS].rem[DB-1:0] < {1'b0, st_reg[NS].mag_b}
                         || st_reg[NS].mag_b == '0))
        else $error("divider remainder not reduced");

endmodule
